/* rtl/jmsp_pkg.sv */
// Package for the JPEG marker segment parser: parse phases, event codes, markers.
// No dependencies.
`default_nettype none
package jmsp_pkg;

    typedef enum logic [4:0] {
        PH_SOI_FF, PH_SOI_D8, PH_MARK_FF, PH_MARK, PH_LEN_HI, PH_LEN_LO,
        PH_APP, PH_COM, PH_DQT_HDR, PH_DQT_ENT, PH_DHT_HDR, PH_DHT_ENT,
        PH_SOF_P, PH_SOF_HH, PH_SOF_HL, PH_SOF_WH, PH_SOF_WL, PH_SOF_N,
        PH_SOF_CID, PH_SOF_SMP, PH_SOF_TQ, PH_SOS_N, PH_SOS_CID, PH_SOS_SEL,
        PH_SOS_SS, PH_SOS_SE, PH_SOS_AA, PH_SCAN, PH_DONE
    } t_phase;

    typedef enum logic [4:0] {
        EV_START = 5'd0, EV_LENGTH = 5'd1, EV_APP_ID = 5'd2, EV_JFIF_MAJ = 5'd3,
        EV_JFIF_MIN = 5'd4, EV_COMMENT = 5'd5, EV_DQT_HDR = 5'd6, EV_DQT_ENT = 5'd7,
        EV_SOF_P = 5'd8, EV_SOF_H = 5'd9, EV_SOF_W = 5'd10, EV_SOF_N = 5'd11,
        EV_SOF_CID = 5'd12, EV_SOF_SMP = 5'd13, EV_SOF_TQ = 5'd14,
        EV_DHT_HDR = 5'd15, EV_DHT_ENT = 5'd16, EV_SOS_N = 5'd17,
        EV_SOS_CID = 5'd18, EV_SOS_SEL = 5'd19, EV_SOS_SS = 5'd20,
        EV_SOS_SE = 5'd21, EV_SOS_AA = 5'd22, EV_DATA = 5'd23, EV_END = 5'd24,
        EV_ERR_START = 5'd25, EV_ERR_MARKER = 5'd26, EV_ERR_DQT = 5'd27,
        EV_ERR_DHT = 5'd28, EV_ERR_SOS = 5'd29
    } t_event;

    localparam logic [7:0] MK_FF   = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_COM  = 8'hFE;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_SOS  = 8'hDA;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  marker;
        logic [15:0] pos;
        logic [15:0] value;
        logic [3:0]  hi;
        logic [3:0]  lo;
    } t_result;

endpackage
`default_nettype wire

/* rtl/jmsp_step.sv */
// Parse state and one-byte step logic; gives at most one result per byte.
// Depends on jmsp_pkg.
`default_nettype none
module jmsp_step
    import jmsp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    output logic            o_emit,
    output t_result         o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [6:0]  r_ent, n_ent;
    logic [7:0]  r_ncomp, n_ncomp;
    logic [7:0]  r_comp, n_comp;
    logic [7:0]  r_hold, n_hold;
    logic        r_wide, n_wide;
    logic        r_ffp, n_ffp;
    logic        r_halt, n_halt;

    logic [3:0]  w_hi, w_lo;
    logic [15:0] w_off, w_cnt1, w_spos;
    logic        w_end;

    assign w_hi   = i_byte[7:4];
    assign w_lo   = i_byte[3:0];
    assign w_off  = r_cnt - 16'd2;
    assign w_cnt1 = r_cnt + 16'd1;
    assign w_end  = (w_cnt1 >= r_len);
    assign w_spos = {7'd0, r_ncomp, 1'b0};

    always_comb begin
        n_phase = r_phase; n_marker = r_marker; n_len = r_len; n_cnt = r_cnt;
        n_ent = r_ent; n_ncomp = r_ncomp; n_comp = r_comp; n_hold = r_hold;
        n_wide = r_wide; n_ffp = r_ffp; n_halt = r_halt;
        o_emit = 1'b0;
        o_res  = '{kind: EV_START, marker: r_marker, pos: 16'd0,
                   value: {8'd0, i_byte}, hi: 4'd0, lo: 4'd0};
        if (i_take && !r_halt && r_phase != PH_DONE) begin
            case (r_phase)
                PH_SOI_FF: begin
                    if (i_byte != MK_FF) begin
                        o_emit = 1'b1; o_res.kind = EV_ERR_START; n_halt = 1'b1;
                    end else n_phase = PH_SOI_D8;
                end
                PH_SOI_D8: begin
                    o_emit = 1'b1;
                    if (i_byte != MK_SOI) begin
                        o_res.kind = EV_ERR_START; n_halt = 1'b1;
                    end else begin
                        n_marker = MK_SOI; o_res.marker = MK_SOI; n_phase = PH_MARK_FF;
                    end
                end
                PH_MARK_FF: begin
                    if (i_byte != MK_FF) begin
                        o_emit = 1'b1; o_res.kind = EV_ERR_MARKER; n_halt = 1'b1;
                    end else n_phase = PH_MARK;
                end
                PH_MARK: begin
                    if (i_byte != MK_FF) begin
                        n_marker = i_byte; o_res.marker = i_byte;
                        if (i_byte == MK_EOI) begin
                            o_emit = 1'b1; o_res.kind = EV_END; n_phase = PH_DONE;
                        end else if (i_byte == MK_APP0 || i_byte == MK_COM ||
                                     i_byte == MK_DQT || i_byte == MK_SOF0 ||
                                     i_byte == MK_DHT || i_byte == MK_SOS) begin
                            n_phase = PH_LEN_HI;
                        end else begin
                            o_emit = 1'b1; o_res.kind = EV_ERR_MARKER; n_halt = 1'b1;
                        end
                    end
                end
                PH_LEN_HI: begin
                    n_hold = i_byte; n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = {r_hold, i_byte}; n_cnt = 16'd2;
                    o_emit = 1'b1; o_res.kind = EV_LENGTH; o_res.value = {r_hold, i_byte};
                    case (r_marker)
                        MK_APP0: n_phase = PH_APP;
                        MK_COM:  n_phase = PH_COM;
                        MK_DQT:  n_phase = PH_DQT_HDR;
                        MK_DHT:  n_phase = PH_DHT_HDR;
                        MK_SOF0: n_phase = PH_SOF_P;
                        default: n_phase = PH_SOS_N;
                    endcase
                    if (r_marker != MK_SOF0 && r_marker != MK_SOS &&
                        {r_hold, i_byte} <= 16'd2)
                        n_phase = PH_MARK_FF;
                end
                PH_APP: begin
                    o_res.pos = w_off;
                    if (w_off < 16'd5) begin
                        o_emit = 1'b1; o_res.kind = EV_APP_ID;
                    end else if (w_off == 16'd5) begin
                        o_emit = 1'b1; o_res.kind = EV_JFIF_MAJ;
                    end else if (w_off == 16'd6) begin
                        o_emit = 1'b1; o_res.kind = EV_JFIF_MIN;
                    end
                    n_cnt = w_cnt1; if (w_end) n_phase = PH_MARK_FF;
                end
                PH_COM: begin
                    o_emit = 1'b1; o_res.kind = EV_COMMENT; o_res.pos = w_off;
                    n_cnt = w_cnt1; if (w_end) n_phase = PH_MARK_FF;
                end
                PH_DQT_HDR: begin
                    o_emit = 1'b1; o_res.hi = w_hi; o_res.lo = w_lo;
                    if (w_hi > 4'd1) begin
                        o_res.kind = EV_ERR_DQT; n_halt = 1'b1;
                    end else begin
                        o_res.kind = EV_DQT_HDR; o_res.pos = w_off;
                        n_wide = w_hi[0]; n_ent = 7'd0; n_ffp = 1'b0;
                        n_cnt = w_cnt1;
                        n_phase = w_end ? PH_MARK_FF : PH_DQT_ENT;
                    end
                end
                PH_DQT_ENT: begin
                    n_cnt = w_cnt1;
                    if (r_wide && !r_ffp) begin
                        n_hold = i_byte; n_ffp = 1'b1;
                        if (w_end) n_phase = PH_MARK_FF;
                    end else begin
                        n_ffp = 1'b0; o_emit = 1'b1; o_res.kind = EV_DQT_ENT;
                        o_res.pos = {9'd0, r_ent};
                        o_res.value = r_wide ? {r_hold, i_byte} : {8'd0, i_byte};
                        n_ent = r_ent + 7'd1;
                        if (w_end) n_phase = PH_MARK_FF;
                        else if (r_ent == 7'd63) n_phase = PH_DQT_HDR;
                    end
                end
                PH_DHT_HDR: begin
                    o_emit = 1'b1; o_res.hi = w_hi; o_res.lo = w_lo;
                    if (w_hi > 4'd1) begin
                        o_res.kind = EV_ERR_DHT; n_halt = 1'b1;
                    end else begin
                        o_res.kind = EV_DHT_HDR; o_res.pos = w_off; n_cnt = w_cnt1;
                        n_phase = w_end ? PH_MARK_FF : PH_DHT_ENT;
                    end
                end
                PH_DHT_ENT: begin
                    o_emit = 1'b1; o_res.kind = EV_DHT_ENT; o_res.pos = r_cnt - 16'd3;
                    n_cnt = w_cnt1; if (w_end) n_phase = PH_MARK_FF;
                end
                PH_SOF_P: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_P; n_phase = PH_SOF_HH;
                end
                PH_SOF_HH: begin
                    n_hold = i_byte; n_phase = PH_SOF_HL;
                end
                PH_SOF_WH: begin
                    n_hold = i_byte; n_phase = PH_SOF_WL;
                end
                PH_SOF_HL: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_H; o_res.pos = 16'd1;
                    o_res.value = {r_hold, i_byte}; n_phase = PH_SOF_WH;
                end
                PH_SOF_WL: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_W; o_res.pos = 16'd3;
                    o_res.value = {r_hold, i_byte}; n_phase = PH_SOF_N;
                end
                PH_SOF_N: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_N; o_res.pos = 16'd5;
                    n_ncomp = i_byte; n_comp = 8'd0;
                    n_phase = (i_byte != 8'd0) ? PH_SOF_CID : PH_MARK_FF;
                end
                PH_SOF_CID: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_CID; o_res.pos = {8'd0, r_comp};
                    n_phase = PH_SOF_SMP;
                end
                PH_SOF_SMP: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_SMP; o_res.pos = {8'd0, r_comp};
                    o_res.hi = w_hi; o_res.lo = w_lo; n_phase = PH_SOF_TQ;
                end
                PH_SOF_TQ: begin
                    o_emit = 1'b1; o_res.kind = EV_SOF_TQ; o_res.pos = {8'd0, r_comp};
                    n_comp = r_comp + 8'd1;
                    n_phase = ({1'b0, r_comp} + 9'd1 >= {1'b0, r_ncomp}) ?
                              PH_MARK_FF : PH_SOF_CID;
                end
                PH_SOS_N: begin
                    o_emit = 1'b1;
                    if ({7'd0, i_byte, 1'b0} + 16'd6 != r_len) begin
                        o_res.kind = EV_ERR_SOS; n_halt = 1'b1;
                    end else begin
                        o_res.kind = EV_SOS_N; n_ncomp = i_byte; n_comp = 8'd0;
                        n_phase = (i_byte != 8'd0) ? PH_SOS_CID : PH_SOS_SS;
                    end
                end
                PH_SOS_CID: begin
                    o_emit = 1'b1; o_res.kind = EV_SOS_CID; o_res.pos = {8'd0, r_comp};
                    n_phase = PH_SOS_SEL;
                end
                PH_SOS_SEL: begin
                    o_emit = 1'b1; o_res.kind = EV_SOS_SEL; o_res.pos = {8'd0, r_comp};
                    o_res.hi = w_hi; o_res.lo = w_lo; n_comp = r_comp + 8'd1;
                    n_phase = ({1'b0, r_comp} + 9'd1 >= {1'b0, r_ncomp}) ?
                              PH_SOS_SS : PH_SOS_CID;
                end
                PH_SOS_SS: begin
                    o_emit = 1'b1; o_res.kind = EV_SOS_SS; o_res.pos = w_spos + 16'd1;
                    n_phase = PH_SOS_SE;
                end
                PH_SOS_SE: begin
                    o_emit = 1'b1; o_res.kind = EV_SOS_SE; o_res.pos = w_spos + 16'd2;
                    n_phase = PH_SOS_AA;
                end
                PH_SOS_AA: begin
                    o_emit = 1'b1; o_res.kind = EV_SOS_AA; o_res.pos = w_spos + 16'd3;
                    o_res.hi = w_hi; o_res.lo = w_lo;
                    n_phase = PH_SCAN; n_cnt = 16'd0; n_ffp = 1'b0;
                end
                PH_SCAN: begin
                    o_res.pos = r_cnt;
                    if (r_ffp) begin
                        n_ffp = 1'b0; o_emit = 1'b1;
                        if (i_byte == MK_EOI) begin
                            n_marker = MK_EOI; o_res.marker = MK_EOI;
                            o_res.kind = EV_END; o_res.pos = 16'd0; n_phase = PH_DONE;
                        end else begin
                            o_res.kind = EV_DATA; o_res.value = {8'd0, MK_FF};
                            n_cnt = w_cnt1;
                        end
                    end else if (i_byte == MK_FF) begin
                        n_ffp = 1'b1;
                    end else begin
                        o_emit = 1'b1; o_res.kind = EV_DATA; n_cnt = w_cnt1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOI_FF; r_marker <= 8'd0; r_len <= 16'd0; r_cnt <= 16'd0;
            r_ent <= 7'd0; r_ncomp <= 8'd0; r_comp <= 8'd0; r_hold <= 8'd0;
            r_wide <= 1'b0; r_ffp <= 1'b0; r_halt <= 1'b0;
        end else begin
            r_phase <= n_phase; r_marker <= n_marker; r_len <= n_len; r_cnt <= n_cnt;
            r_ent <= n_ent; r_ncomp <= n_ncomp; r_comp <= n_comp; r_hold <= n_hold;
            r_wide <= n_wide; r_ffp <= n_ffp; r_halt <= n_halt;
        end
    end

endmodule
`default_nettype wire

/* rtl/jpeg_marker_segment_parser_core.sv */
// Top level of the JPEG marker segment parser: input register, step logic, output skid.
// Depends on jmsp_pkg and jmsp_step.
`default_nettype none
// Takes one file byte per cycle while o_stall is low and gives at most one event
// per byte. A byte is registered on entry, stepped through the parse logic in the
// next cycle, and its event lands in a two-entry output buffer; the sustained rate
// is one byte per cycle while the output side keeps up. Bytes that produce no event
// (fill FFs, length high bytes, skipped APP0 tail) vanish.
// After an error event or the end-of-image event nothing more comes out until reset.
module jpeg_marker_segment_parser_core
    import jmsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_event_kind,
    output logic [7:0]       o_marker_code,
    output logic [15:0]      o_position,
    output logic [15:0]      o_field_value,
    output logic [3:0]       o_high_nibble,
    output logic [3:0]       o_low_nibble
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       w_emit;
    t_result    w_res;
    t_result    r_q0, r_q1;
    logic       r_v0, r_v1;
    logic       w_pop;

    // stall when the buffer could not absorb the byte in flight plus a new one;
    // a head transaction leaving this cycle frees the room
    assign o_stall = r_v1 || (r_v0 && r_in_vld && i_stall);
    assign w_pop   = r_v0 && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_vld <= 1'b0;
        else          r_in_vld <= i_valid && !o_stall;
        if (i_valid && !o_stall) r_in_byte <= i_data_byte;
    end

    jmsp_step u_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (r_in_vld),
        .i_byte (r_in_byte),
        .o_emit (w_emit),
        .o_res  (w_res)
    );

    logic w_push;
    assign w_push = r_in_vld && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            case ({w_push, w_pop})
                2'b10: begin
                    if (!r_v0) r_v0 <= 1'b1; else r_v1 <= 1'b1;
                end
                2'b01: begin
                    r_v0 <= r_v1; r_v1 <= 1'b0;
                end
                default: ;
            endcase
        end
        case ({w_push, w_pop})
            2'b10:   if (!r_v0) r_q0 <= w_res; else r_q1 <= w_res;
            2'b01:   r_q0 <= r_q1;
            2'b11:   if (r_v1) begin r_q0 <= r_q1; r_q1 <= w_res; end
                     else r_q0 <= w_res;
            default: ;
        endcase
    end

    assign o_valid       = r_v0;
    assign o_event_kind  = r_q0.kind;
    assign o_marker_code = r_q0.marker;
    assign o_position    = r_q0.pos;
    assign o_field_value = r_q0.value;
    assign o_high_nibble = r_q0.hi;
    assign o_low_nibble  = r_q0.lo;

endmodule
`default_nettype wire
